/* design/mbs_pkg.sv */
// mbs_pkg: shared types, constants and the palette lookup of the metaball pixel shader
// no dependencies; used by mbs_div, metaball_pixel_shader and mbs_checker
package mbs_pkg;

    // fixed field widths
    localparam int COORD_W = 12;
    localparam int MASS_W  = 20;
    localparam int CH_W    = 8;
    localparam int QUO_W   = 8;
    localparam int CFG_W   = 8;

    // shared divider runs one saturation step and then one step per quotient bit
    localparam int STEP_W    = 4;
    localparam int SAT_STEP  = QUO_W;

    // palette constants
    localparam logic [CH_W-1:0] CH_MAX     = 8'hFF;
    localparam logic [CH_W-1:0] PLASMA_TOP = 8'hFC;
    localparam int              GRAY_STEP  = 5;
    localparam int              RAMP_SHIFT = 2;

    // input word kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    // configuration register indexes
    typedef enum logic {
        REG_PALETTE_MODE = 1'b0,
        REG_BALL_COUNT   = 1'b1
    } cfg_reg_t;

    // palette modes
    localparam logic MODE_GRAY   = 1'b0;
    localparam logic MODE_PLASMA = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_t;

    // palette entry for index idx under the given mode
    function automatic rgb_t palette_entry(input logic mode, input logic [CH_W-1:0] idx);
        rgb_t            c;
        logic [10:0]     prod5;
        logic [CH_W-1:0] ramp;
        c     = '0;
        prod5 = 11'(idx) * 11'(GRAY_STEP);
        ramp  = '0;
        if (mode == MODE_GRAY)
        begin
            if (prod5 >= 11'(CH_MAX))
            begin
                c = '0;
            end
            else
            begin
                c.red   = CH_MAX - prod5[CH_W-1:0];
                c.green = CH_MAX - prod5[CH_W-1:0];
                c.blue  = CH_MAX - prod5[CH_W-1:0];
            end
        end
        else if (idx <= 8'd62)
        begin
            ramp  = idx + 8'd1;
            c.red = ramp << RAMP_SHIFT;
        end
        else if (idx <= 8'd125)
        begin
            ramp    = idx - 8'd62;
            c.red   = PLASMA_TOP;
            c.green = ramp << RAMP_SHIFT;
        end
        else if (idx <= 8'd188)
        begin
            ramp    = idx - 8'd125;
            c.red   = PLASMA_TOP;
            c.green = PLASMA_TOP;
            c.blue  = ramp << RAMP_SHIFT;
        end
        else
        begin
            c.red   = PLASMA_TOP;
            c.green = PLASMA_TOP;
            c.blue  = PLASMA_TOP;
        end
        return c;
    endfunction

endpackage

/* design/mbs_div.sv */
// mbs_div: shared restoring divider with an 8-bit quotient that saturates at 255
// depends on mbs_pkg for step and quotient widths
module mbs_div #(
    parameter int DVD_W = 20,
    parameter int DVS_W = 25
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DVD_W-1:0]         dividend,
    input  logic [DVS_W-1:0]         divisor,
    output logic                     done,
    output logic [mbs_pkg::QUO_W-1:0] quotient
);

    localparam int SH_W  = DVS_W + mbs_pkg::QUO_W;
    localparam int CMP_W = (SH_W > DVD_W) ? SH_W : DVD_W;

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [mbs_pkg::STEP_W-1:0] step_reg, step_next;
    logic [DVD_W-1:0]          rem_reg, rem_next;
    logic [SH_W-1:0]           dsh_reg, dsh_next;
    logic [mbs_pkg::QUO_W-1:0] quo_reg, quo_next;

    logic [CMP_W-1:0] rem_ext, dsh_ext, diff;
    logic             ge;

    // one compare and subtract per cycle against the shifted divisor
    assign rem_ext = CMP_W'(rem_reg);
    assign dsh_ext = CMP_W'(dsh_reg);
    assign ge      = rem_ext >= dsh_ext;
    assign diff    = rem_ext - dsh_ext;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            rem_next  = dividend;
            dsh_next  = {divisor, {mbs_pkg::QUO_W{1'b0}}};
            step_next = mbs_pkg::STEP_W'(mbs_pkg::SAT_STEP);
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            dsh_next  = dsh_reg >> 1;
            step_next = step_reg - 1'b1;
            if (step_reg == mbs_pkg::STEP_W'(mbs_pkg::SAT_STEP))
            begin
                // quotient of 256 or more saturates at once
                if (ge)
                begin
                    quo_next  = mbs_pkg::CH_MAX;
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
            else
            begin
                quo_next = {quo_reg[mbs_pkg::QUO_W-2:0], ge};
                if (ge)
                begin
                    rem_next = DVD_W'(diff);
                end
                if (step_reg == '0)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* design/metaball_pixel_shader.sv */
// metaball_pixel_shader: ball table, per-ball sequencer and palette output register
// depends on mbs_pkg and mbs_div
//
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+---------------------------------------------
// in       | in        | in_valid/in_ready  | kind ball_index ball_x ball_y ball_mass
//          |           |                    | pixel_x pixel_y
// out      | out       | out_valid/out_ready| red green blue
// cfg      | in        | cfg_valid/cfg_ready| cfg_index cfg_data
//
// a load word is written to the table in the cycle it is taken; in_ready stays high
// a pixel word steps through the active balls: table read, square dx, square dy, divide
// mass by squared distance (255 at zero), accumulate; then divide the sum by ball count
// in_ready is low while a pixel is in work; the finished color sits in the output
// register, so the next word is taken while the color waits for out_ready
// reset clears the sequencer and configuration; the ball table is not cleared
module metaball_pixel_shader #(
    parameter int BALL_SLOTS = 128,
    parameter int COORD_BITS = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        kind,
    input  logic [6:0]                  ball_index,
    input  logic [mbs_pkg::COORD_W-1:0] ball_x,
    input  logic [mbs_pkg::COORD_W-1:0] ball_y,
    input  logic [mbs_pkg::MASS_W-1:0]  ball_mass,
    input  logic [mbs_pkg::COORD_W-1:0] pixel_x,
    input  logic [mbs_pkg::COORD_W-1:0] pixel_y,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [mbs_pkg::CH_W-1:0]    red,
    output logic [mbs_pkg::CH_W-1:0]    green,
    output logic [mbs_pkg::CH_W-1:0]    blue,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [mbs_pkg::CFG_W-1:0]   cfg_data
);

    localparam int CW    = (COORD_BITS < mbs_pkg::COORD_W) ? COORD_BITS : mbs_pkg::COORD_W;
    localparam int IDX_W = (BALL_SLOTS > 1) ? $clog2(BALL_SLOTS) : 1;
    localparam int CNT_W = $clog2(BALL_SLOTS + 1);
    localparam int SUM_W = $clog2(BALL_SLOTS * 255 + 1);
    localparam int D_W   = 2 * CW + 1;
    localparam int DV_W  = (D_W > CNT_W) ? D_W : CNT_W;
    localparam int RM_W  = (SUM_W > mbs_pkg::MASS_W) ? SUM_W : mbs_pkg::MASS_W;
    localparam int MEM_W = 2 * CW + mbs_pkg::MASS_W;
    localparam int SEL_W = 9;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_SQX,
        S_SQY,
        S_DIVB,
        S_WAITB,
        S_ACC,
        S_DIVA,
        S_WAITA,
        S_EMIT
    } state_t;

    // ball table: one word holds x, y and mass
    logic [MEM_W-1:0] ball_mem [BALL_SLOTS];
    logic [MEM_W-1:0] rd_word_reg;

    state_t                     state_reg, state_next;
    logic                       mode_reg, mode_next;
    logic [mbs_pkg::CFG_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]           n_reg, n_next;
    logic [CNT_W-1:0]           k_reg, k_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [CW-1:0]              px_reg, px_next;
    logic [CW-1:0]              py_reg, py_next;
    logic [2*CW-1:0]            sq_reg, sq_next;
    logic [D_W-1:0]             d_reg, d_next;
    logic [mbs_pkg::QUO_W-1:0]  term_reg, term_next;
    logic [mbs_pkg::QUO_W-1:0]  avg_reg, avg_next;
    logic                       ov_reg, ov_next;
    mbs_pkg::rgb_t              rgb_reg, rgb_next;

    logic                       in_take, ld_take, px_take, wr_en;
    logic [SEL_W-1:0]           slot_ext, count_ext;
    logic [CW-1:0]              rd_x, rd_y, dx, dy, mul_in;
    logic [mbs_pkg::MASS_W-1:0] rd_mass;
    logic [2*CW-1:0]            mul_op, prod;
    logic                       div_start, div_done;
    logic [RM_W-1:0]            div_dvd;
    logic [DV_W-1:0]            div_dvs;
    logic [mbs_pkg::QUO_W-1:0]  div_quo;

    // handshakes
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_take   = in_valid && in_ready;
    assign ld_take   = in_take && (kind == mbs_pkg::KIND_LOAD);
    assign px_take   = in_take && (kind == mbs_pkg::KIND_PIXEL);
    assign slot_ext  = SEL_W'(ball_index);
    assign wr_en     = ld_take && (slot_ext < SEL_W'(BALL_SLOTS));

    // table write on load, registered read at the ball counter
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ball_mem[slot_ext[IDX_W-1:0]] <= {ball_x[CW-1:0], ball_y[CW-1:0], ball_mass};
        end
        rd_word_reg <= ball_mem[k_reg[IDX_W-1:0]];
    end

    assign rd_x    = rd_word_reg[MEM_W-1 -: CW];
    assign rd_y    = rd_word_reg[mbs_pkg::MASS_W +: CW];
    assign rd_mass = rd_word_reg[mbs_pkg::MASS_W-1:0];

    // distance and one shared squarer
    assign dx     = (rd_x > px_reg) ? rd_x - px_reg : px_reg - rd_x;
    assign dy     = (rd_y > py_reg) ? rd_y - py_reg : py_reg - rd_y;
    assign mul_in = (state_reg == S_SQX) ? dx : dy;
    assign mul_op = (2*CW)'(mul_in);
    assign prod   = mul_op * mul_op;

    // shared divider: mass by squared distance per ball, then sum by ball count
    assign div_start = ((state_reg == S_DIVB) && (d_reg != '0)) || (state_reg == S_DIVA);
    assign div_dvd   = (state_reg == S_DIVA) ? RM_W'(sum_reg) : RM_W'(rd_mass);
    assign div_dvs   = (state_reg == S_DIVA) ? DV_W'(n_reg) : DV_W'(d_reg);

    mbs_div #(
        .DVD_W (RM_W),
        .DVS_W (DV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    // effective ball count: zero counts as one, capped at the table size
    assign count_ext = SEL_W'(count_reg);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        count_next = count_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        sum_next   = sum_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        sq_next    = sq_reg;
        d_next     = d_reg;
        term_next  = term_reg;
        avg_next   = avg_reg;
        ov_next    = ov_reg;
        rgb_next   = rgb_reg;

        // configuration write
        if (cfg_valid && cfg_ready)
        begin
            case (mbs_pkg::cfg_reg_t'(cfg_index))
                mbs_pkg::REG_PALETTE_MODE: mode_next  = cfg_data[0];
                mbs_pkg::REG_BALL_COUNT:   count_next = cfg_data;
                default:                   mode_next  = mode_reg;
            endcase
        end

        // output word taken
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (px_take)
                begin
                    px_next  = pixel_x[CW-1:0];
                    py_next  = pixel_y[CW-1:0];
                    k_next   = '0;
                    sum_next = '0;
                    if (count_ext == '0)
                    begin
                        n_next = CNT_W'(1);
                    end
                    else if (count_ext > SEL_W'(BALL_SLOTS))
                    begin
                        n_next = CNT_W'(BALL_SLOTS);
                    end
                    else
                    begin
                        n_next = CNT_W'(count_ext);
                    end
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_SQX;
            end
            S_SQX:
            begin
                sq_next    = prod;
                state_next = S_SQY;
            end
            S_SQY:
            begin
                d_next     = D_W'(sq_reg) + D_W'(prod);
                state_next = S_DIVB;
            end
            S_DIVB:
            begin
                if (d_reg == '0)
                begin
                    term_next  = mbs_pkg::CH_MAX;
                    state_next = S_ACC;
                end
                else
                begin
                    state_next = S_WAITB;
                end
            end
            S_WAITB:
            begin
                if (div_done)
                begin
                    term_next  = div_quo;
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                sum_next = sum_reg + SUM_W'(term_reg);
                if (k_reg + 1'b1 == n_reg)
                begin
                    state_next = S_DIVA;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            S_DIVA:
            begin
                state_next = S_WAITA;
            end
            S_WAITA:
            begin
                if (div_done)
                begin
                    avg_next   = div_quo;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // load the output register once it is free
                if (!ov_reg || out_ready)
                begin
                    rgb_next   = mbs_pkg::palette_entry(mode_reg, avg_reg);
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg  <= mbs_pkg::MODE_GRAY;
            count_reg <= mbs_pkg::CFG_W'(1);
            n_reg     <= CNT_W'(1);
            k_reg     <= '0;
            sum_reg   <= '0;
            ov_reg    <= 1'b0;
            rgb_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            count_reg <= count_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
            sum_reg   <= sum_next;
            ov_reg    <= ov_next;
            rgb_reg   <= rgb_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        px_reg   <= px_next;
        py_reg   <= py_next;
        sq_reg   <= sq_next;
        d_reg    <= d_next;
        term_reg <= term_next;
        avg_reg  <= avg_next;
    end

    assign out_valid = ov_reg;
    assign red       = rgb_reg.red;
    assign green     = rgb_reg.green;
    assign blue      = rgb_reg.blue;

endmodule

/* design/mbs_checker.sv */
// mbs_checker: port-level assertions for metaball_pixel_shader, bound to the top level
// depends on mbs_pkg and metaball_pixel_shader
module mbs_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        kind,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [mbs_pkg::CH_W-1:0]    red,
    input logic [mbs_pkg::CH_W-1:0]    green,
    input logic [mbs_pkg::CH_W-1:0]    blue,
    input logic                        cfg_ready
);

    // a pixel word keeps the input side closed while it is shaded
    a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == mbs_pkg::KIND_PIXEL) |=> !in_ready)
        else $error("input open right after a pixel word");

    // a load word finishes in its own cycle
    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (kind == mbs_pkg::KIND_LOAD) |=> in_ready)
        else $error("input closed after a load word");

    // a new color only appears at the end of pixel work
    a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("color word without pixel work");

    // a waiting color word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
            && $stable(blue))
        else $error("waiting color word changed");

    // configuration port never stalls
    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port stalled");

endmodule

bind metaball_pixel_shader mbs_checker u_mbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .cfg_ready (cfg_ready)
);

/* test/tb_metaball_pixel_shader.sv */
// tb_metaball_pixel_shader: self-checking testbench for the metaball pixel shader
// keeps its own ball table and palette to predict each shaded color word
// depends on mbs_pkg and the metaball_pixel_shader RTL only
module tb_metaball_pixel_shader;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS      = 128;
    localparam int DRAIN_WAIT = 16;
    localparam int TAIL_WAIT  = 2000;
    localparam int HOLD_LEN   = 400;
    localparam int IDLE_PCT   = 26;

    // one input word as the sender sees it
    typedef struct {
        logic                        kind;
        logic [6:0]                  slot;
        logic [mbs_pkg::COORD_W-1:0] bx;
        logic [mbs_pkg::COORD_W-1:0] by;
        logic [mbs_pkg::MASS_W-1:0]  mass;
        logic [mbs_pkg::COORD_W-1:0] px;
        logic [mbs_pkg::COORD_W-1:0] py;
    } shade_word_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic                        kind;
    logic [6:0]                  ball_index;
    logic [mbs_pkg::COORD_W-1:0] ball_x;
    logic [mbs_pkg::COORD_W-1:0] ball_y;
    logic [mbs_pkg::MASS_W-1:0]  ball_mass;
    logic [mbs_pkg::COORD_W-1:0] pixel_x;
    logic [mbs_pkg::COORD_W-1:0] pixel_y;
    logic                        out_valid;
    logic                        out_ready;
    logic [mbs_pkg::CH_W-1:0]    red;
    logic [mbs_pkg::CH_W-1:0]    green;
    logic [mbs_pkg::CH_W-1:0]    blue;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic                        cfg_index;
    logic [mbs_pkg::CFG_W-1:0]   cfg_data;

    // predicted block state
    logic [mbs_pkg::COORD_W-1:0] ball_x_tab [SLOTS];
    logic [mbs_pkg::COORD_W-1:0] ball_y_tab [SLOTS];
    logic [mbs_pkg::MASS_W-1:0]  ball_mass_tab [SLOTS];
    logic                        mode_reg = mbs_pkg::MODE_GRAY;
    logic [7:0]                  count_reg = 8'd1;

    mbs_pkg::rgb_t color_q[$];
    int            mismatches = 0;
    bit            calm = 1'b0;
    int            hold_requests = 0;

    metaball_pixel_shader uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .ball_index (ball_index),
        .ball_x     (ball_x),
        .ball_y     (ball_y),
        .ball_mass  (ball_mass),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(30_000_000);
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // palette lookup for an averaged field level
    function automatic mbs_pkg::rgb_t level_color(input logic mode, input logic [7:0] level);
        mbs_pkg::rgb_t c;
        int            i;
        int            v;
        i = level;
        c = '0;
        if (mode == mbs_pkg::MODE_GRAY)
        begin
            v = (5 * i >= 255) ? 0 : 255 - 5 * i;
            c.red   = 8'(v);
            c.green = 8'(v);
            c.blue  = 8'(v);
        end
        else if (i <= 62)
        begin
            c.red = 8'(4 * (i + 1));
        end
        else if (i <= 125)
        begin
            c.red   = 8'hFC;
            c.green = 8'(4 * (i - 62));
        end
        else if (i <= 188)
        begin
            c.red   = 8'hFC;
            c.green = 8'hFC;
            c.blue  = 8'(4 * (i - 125));
        end
        else
        begin
            c.red   = 8'hFC;
            c.green = 8'hFC;
            c.blue  = 8'hFC;
        end
        return c;
    endfunction

    // sum of capped field terms over the active balls, averaged
    function automatic mbs_pkg::rgb_t shade_color(input logic [mbs_pkg::COORD_W-1:0] px,
                                                  input logic [mbs_pkg::COORD_W-1:0] py);
        int unsigned n;
        int unsigned sum;
        int unsigned dx;
        int unsigned dy;
        int unsigned dsq;
        int unsigned term;
        n   = count_reg;
        sum = 0;
        if (n == 0)
            n = 1;
        if (n > SLOTS)
            n = SLOTS;
        for (int k = 0; k < n; k++)
        begin
            dx  = (ball_x_tab[k] > px) ? ball_x_tab[k] - px : px - ball_x_tab[k];
            dy  = (ball_y_tab[k] > py) ? ball_y_tab[k] - py : py - ball_y_tab[k];
            dsq = dx * dx + dy * dy;
            if (dsq == 0)
                term = 255;
            else
            begin
                term = ball_mass_tab[k] / dsq;
                if (term > 255)
                    term = 255;
            end
            sum += term;
        end
        return level_color(mode_reg, 8'(sum / n));
    endfunction

    // check each color word against the oldest prediction
    always @(posedge clk)
    begin : check_colors
        mbs_pkg::rgb_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (color_q.size() == 0)
                report_mismatch("color word with no pixel pending");
            else
            begin
                want = color_q.pop_front();
                if (red !== want.red)
                    report_mismatch($sformatf("red %0h, want %0h", red, want.red));
                if (green !== want.green)
                    report_mismatch($sformatf("green %0h, want %0h", green, want.green));
                if (blue !== want.blue)
                    report_mismatch($sformatf("blue %0h, want %0h", blue, want.blue));
            end
        end
    end

    // receiver: random stalls, a calm stretch, and long holds on request
    initial
    begin : color_sink
        int hold_left;
        int holds_done;
        hold_left  = 0;
        holds_done = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_done != hold_requests)
            begin
                holds_done = hold_requests;
                hold_left  = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (calm)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // offer one word, keep valid high after acceptance, update the prediction
    task automatic send_word(input shade_word_t w);
        int gap;
        gap = 0;
        while (!calm && $urandom_range(99) < IDLE_PCT)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= w.kind;
        ball_index <= w.slot;
        ball_x     <= w.bx;
        ball_y     <= w.by;
        ball_mass  <= w.mass;
        pixel_x    <= w.px;
        pixel_y    <= w.py;
        do @(posedge clk); while (!in_ready);
        if (w.kind == mbs_pkg::KIND_LOAD)
        begin
            ball_x_tab[w.slot]    = w.bx;
            ball_y_tab[w.slot]    = w.by;
            ball_mass_tab[w.slot] = w.mass;
        end
        else
            color_q.push_back(shade_color(w.px, w.py));
    endtask

    task automatic load_ball(input int slot, input int x, input int y, input int mass);
        shade_word_t w;
        w.kind = mbs_pkg::KIND_LOAD;
        w.slot = 7'(slot);
        w.bx   = 12'(x);
        w.by   = 12'(y);
        w.mass = 20'(mass);
        w.px   = 12'($urandom);
        w.py   = 12'($urandom);
        send_word(w);
    endtask

    task automatic shade(input int x, input int y);
        shade_word_t w;
        w.kind = mbs_pkg::KIND_PIXEL;
        w.slot = 7'($urandom);
        w.bx   = 12'($urandom);
        w.by   = 12'($urandom);
        w.mass = 20'($urandom);
        w.px   = 12'(x);
        w.py   = 12'(y);
        send_word(w);
    endtask

    // stop offering and wait until every color word has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (color_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic set_config(input mbs_pkg::cfg_reg_t which, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        if (which == mbs_pkg::REG_PALETTE_MODE)
            mode_reg = data[0];
        else
            count_reg = data;
    endtask

    // palette mode goes with random upper data bits
    task automatic configure(input logic mode, input logic [7:0] count);
        set_config(mbs_pkg::REG_PALETTE_MODE, {7'($urandom), mode});
        set_config(mbs_pkg::REG_BALL_COUNT, count);
        cfg_valid <= 1'b0;
    endtask

    // mass with a random magnitude, sometimes zero or full scale
    function automatic int pick_mass();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0)
            return 0;
        if (sel == 1)
            return 20'hFFFFF;
        return $urandom & ((1 << $urandom_range(1, 20)) - 1);
    endfunction

    // pixel on, near, or far from one of the active balls
    task automatic shade_near(input int n_eff, input int spread);
        int k;
        int r;
        k = $urandom_range(0, n_eff - 1);
        r = $urandom_range(99);
        if (r < 8)
            shade($urandom, $urandom);
        else if (r < 25)
            shade(ball_x_tab[k], ball_y_tab[k]);
        else
            shade(ball_x_tab[k] + $urandom_range(0, 2 * spread) - spread,
                  ball_y_tab[k] + $urandom_range(0, 2 * spread) - spread);
    endtask

    // gray palette with the reset configuration: one ball, extremes of the fields
    task automatic test_gray_palette();
        load_ball(0, 0, 0, 20'hFFFFF);
        shade(0, 0);
        shade(4095, 4095);
        load_ball(127, 4095, 4095, 0);
        // zero mass still counts fully on the ball itself
        load_ball(0, 4095, 0, 0);
        shade(4095, 0);
        shade(0, 4095);
        load_ball(0, 7, 9, 51);
        shade(8, 9);
    endtask

    // plasma band edges with one ball at unit distance
    task automatic test_plasma_bands();
        int band_edges[5];
        band_edges = '{63, 125, 126, 188, 189};
        wait_idle();
        configure(mbs_pkg::MODE_PLASMA, 8'd1);
        load_ball(0, 2048, 2048, 62);
        shade(2049, 2048);
        shade(2048, 2048);
        shade(0, 0);
        foreach (band_edges[i])
        begin
            load_ball(0, 2048, 2048, band_edges[i]);
            shade(2048, 2049);
        end
    endtask

    // fill the whole ball table so any ball count is safe afterwards
    task automatic test_table_fill();
        int cx;
        int cy;
        cx = $urandom_range(0, 4095);
        cy = $urandom_range(0, 4095);
        for (int s = 0; s < SLOTS; s++)
            load_ball(s, cx + $urandom_range(0, 80) - 40,
                      cy + $urandom_range(0, 80) - 40, pick_mass());
    endtask

    // receiver holds off while pixels keep coming, then the sender waits out the backlog
    task automatic test_backpressure();
        wait_idle();
        configure(mbs_pkg::MODE_PLASMA, 8'd2);
        hold_requests++;
        for (int i = 0; i < 40; i++)
            shade_near(2, 12);
        wait_idle();
    endtask

    // one configuration, a cluster of active balls for counts up to 40, then mixed loads and pixels
    task automatic run_phase(input logic [7:0] count, input int n_items);
        int n_eff;
        int spread;
        int cx;
        int cy;
        int sel;
        n_eff  = (count == 0) ? 1 : ((count > SLOTS) ? SLOTS : count);
        sel    = $urandom_range(2);
        spread = (sel == 0) ? 2 : ((sel == 1) ? 12 : 40);
        cx     = $urandom_range(0, 4095);
        cy     = $urandom_range(0, 4095);
        wait_idle();
        configure($urandom_range(1), count);
        if (n_eff <= 40)
            for (int k = 0; k < n_eff; k++)
                load_ball(k, cx + $urandom_range(0, 2 * spread) - spread,
                          cy + $urandom_range(0, 2 * spread) - spread, pick_mass());
        for (int i = 0; i < n_items; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 8)
                load_ball($urandom_range(0, SLOTS - 1), $urandom, $urandom, $urandom);
            else if (sel < 16)
                load_ball($urandom_range(0, SLOTS - 1),
                          cx + $urandom_range(0, 2 * spread) - spread,
                          cy + $urandom_range(0, 2 * spread) - spread, pick_mass());
            else
                shade_near(n_eff, spread);
        end
    endtask

    // random phases: mostly few balls, some medium, a few full table, count edge values
    task automatic test_random_phases();
        for (int p = 0; p < 14; p++)
        begin
            calm = (p == 2);
            if (p == 3)
                run_phase(8'd128, 15);
            else if (p == 7)
                run_phase(8'd255, 15);
            else if (p == 10)
                run_phase(8'd0, 120);
            else if (p % 4 == 1)
                run_phase(8'($urandom_range(9, 40)), 100);
            else
                run_phase(8'($urandom_range(1, 8)), 150);
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        kind       <= mbs_pkg::KIND_LOAD;
        ball_index <= '0;
        ball_x     <= '0;
        ball_y     <= '0;
        ball_mass  <= '0;
        pixel_x    <= '0;
        pixel_y    <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= mbs_pkg::REG_PALETTE_MODE;
        cfg_data   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_gray_palette();
        test_plasma_bands();
        test_table_fill();
        test_backpressure();
        test_random_phases();

        wait_idle();
        repeat (TAIL_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
